// ===== design/assert_macros.svh =====
// assertion macros shared by the rotate point about pivot rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPP_ASSERT_IMP(label, clk_s, rst_ns, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_ns)) (ante) |-> (cons)) \
    else $error("rpp assertion failed");
`define RPP_ASSERT_NXT(label, clk_s, rst_ns, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_ns)) (ante) |=> (cons)) \
    else $error("rpp assertion failed");
`else
`define RPP_ASSERT_IMP(label, clk_s, rst_ns, ante, cons)
`define RPP_ASSERT_NXT(label, clk_s, rst_ns, ante, cons)
`endif
`endif

// ===== design/rpp_pkg.sv =====
// types, constants and elaboration functions for the point rotation core
package rpp_pkg;

  // cordic datapath width and the fixed sum of coordinate plus guard bits
  localparam int CW          = 62;
  localparam int GUARD_TOTAL = 58;
  localparam int ANG_W       = 32;
  localparam int RW          = 24;
  localparam int MAGW        = CW - 1;

  // angle reduction: magnitude mod 360 degrees via reciprocal multiply
  localparam int          DEG_TURN    = 360;
  localparam logic [15:0] RECIP_360   = 16'd46604;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [24:0] DEG_90      = 25'(90 * 65536);
  localparam logic [24:0] DEG_180     = 25'(180 * 65536);
  localparam logic [24:0] DEG_270     = 25'(270 * 65536);
  localparam logic [24:0] DEG_360     = 25'(360 * 65536);

  // folded angle times 5^16, split in two partial products
  localparam logic [63:0]       FIVE_POW_16 = 64'd152587890625;
  localparam int                ZSPLIT      = 19;
  localparam logic [ZSPLIT-1:0] Z_LO        = FIVE_POW_16[ZSPLIT-1:0];
  localparam logic [ZSPLIT-1:0] Z_HI        = FIVE_POW_16[2*ZSPLIT-1:ZSPLIT];

  typedef logic signed [CW-1:0] cword_t;

  typedef struct packed {
    cword_t x;
    cword_t y;
    cword_t z;
  } cvec_t;

  // atan(2^-i) in units of 1e-16 degree
  localparam cword_t ATAN_TBL [0:31] = '{
    62'sd450000000000000000, 62'sd265650511770779900, 62'sd140362434679264790,
    62'sd71250163489017980,  62'sd35763343749973510,  62'sd17899106082460690,
    62'sd8951737102110744,   62'sd4476141708605531,   62'sd2238105003685381,
    62'sd1119056770662069,   62'sd559528918938037,    62'sd279764526170037,
    62'sd139882271422650,    62'sd69941136753529,     62'sd34970568507040,
    62'sd17485284269804,     62'sd8742642136938,      62'sd4371321068723,
    62'sd2185660534393,      62'sd1092830267201,      62'sd546415133601,
    62'sd273207566800,       62'sd136603783400,       62'sd68301891700,
    62'sd34150945850,        62'sd17075472925,        62'sd8537736463,
    62'sd4268868231,         62'sd2134434116,         62'sd1067217058,
    62'sd533608529,          62'sd266804264
  };

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem_v;
    res   = '0;
    bit_v = 64'd1 << 62;
    rem_v = n;
    for (int j = 0; j < 32; j++) begin
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res   = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // sqrt of the cordic gain product in q60, used to form 1/k in q31
  function automatic logic [63:0] gain_sqrt(input int stages);
    logic [63:0] p;
    logic [63:0] s;
    p = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < stages) begin
        p = p + (p >> (2 * i));
      end
    end
    s = isqrt64(p);
    if (s == 64'd0) begin
      s = 64'd1;
    end
    return s;
  endfunction

endpackage

// ===== design/rpp_front.sv =====
// front end: offsets, angle reduction mod 360, quadrant fold and cordic setup
module rpp_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_WIDTH-1:0]  point_x,
  input  logic signed [COORD_WIDTH-1:0]  point_y,
  input  logic signed [COORD_WIDTH-1:0]  pivot_x,
  input  logic signed [COORD_WIDTH-1:0]  pivot_y,
  input  logic signed [rpp_pkg::ANG_W-1:0] angle_deg,
  output logic                           vec_valid,
  output rpp_pkg::cvec_t                 vec,
  output logic signed [COORD_WIDTH-1:0]  vec_pivot_x,
  output logic signed [COORD_WIDTH-1:0]  vec_pivot_y
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int GUARD = rpp_pkg::GUARD_TOTAL - W;
  localparam int PW    = rpp_pkg::RW + rpp_pkg::ZSPLIT + 1;

  logic [5:0] valid_r;

  // stage 1
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_dx_nxt, s1_dy_nxt;
  logic signed [W-1:0]  s1_qx_r, s1_qy_r;
  logic                 s1_neg_r;
  logic [31:0]          s1_mag_r, s1_mag_nxt;
  // stage 2
  logic signed [DW-1:0] s2_dx_r, s2_dy_r;
  logic signed [W-1:0]  s2_qx_r, s2_qy_r;
  logic                 s2_neg_r;
  logic [15:0]          s2_h_r, s2_low_r;
  logic [31:0]          s2_prod_r;
  // stage 3
  logic signed [DW-1:0] s3_dx_r, s3_dy_r;
  logic signed [W-1:0]  s3_qx_r, s3_qy_r;
  logic                 s3_neg_r;
  logic [24:0]          s3_m_r;
  logic [7:0]           s3_q;
  logic [16:0]          s3_rem0, s3_rem;
  // stage 4
  logic signed [DW-1:0] s4_dx_r, s4_dy_r;
  logic signed [W-1:0]  s4_qx_r, s4_qy_r;
  logic signed [rpp_pkg::RW-1:0] s4_r_r;
  logic                 s4_flip_r, s4_flip_nxt;
  logic                 s4_le90, s4_lt270;
  logic [24:0]          s4_off;
  logic [25:0]          s4_a, s4_b, s4_diff;
  // stage 5
  logic signed [W-1:0]  s5_qx_r, s5_qy_r;
  logic signed [PW-1:0] s5_pl_r, s5_ph_r;
  rpp_pkg::cword_t      s5_x_r, s5_y_r;
  logic signed [DW-1:0] s5_dxf, s5_dyf;
  // stage 6
  rpp_pkg::cvec_t       s6_vec_r;
  logic signed [W-1:0]  s6_qx_r, s6_qy_r;

  always_comb begin
    s1_dx_nxt  = DW'(point_x) - DW'(pivot_x);
    s1_dy_nxt  = DW'(point_y) - DW'(pivot_y);
    s1_mag_nxt = angle_deg[31] ? (~angle_deg + 32'd1) : angle_deg;
  end

  // remainder of the integer degrees by 360, one correction step
  always_comb begin
    s3_q    = s2_prod_r[31:rpp_pkg::RECIP_SHIFT];
    s3_rem0 = {1'b0, s2_h_r} - 17'(s3_q) * 17'(rpp_pkg::DEG_TURN);
    s3_rem  = (s3_rem0 >= 17'(rpp_pkg::DEG_TURN)) ?
              s3_rem0 - 17'(rpp_pkg::DEG_TURN) : s3_rem0;
  end

  // fold magnitude into [-90, 90] with the sign of the input
  always_comb begin
    s4_le90     = (s3_m_r <= rpp_pkg::DEG_90);
    s4_lt270    = (s3_m_r < rpp_pkg::DEG_270);
    s4_flip_nxt = !s4_le90 && s4_lt270;
    if (s4_le90) begin
      s4_off = '0;
    end else if (s4_lt270) begin
      s4_off = rpp_pkg::DEG_180;
    end else begin
      s4_off = rpp_pkg::DEG_360;
    end
    s4_a    = s3_neg_r ? {1'b0, s4_off} : {1'b0, s3_m_r};
    s4_b    = s3_neg_r ? {1'b0, s3_m_r} : {1'b0, s4_off};
    s4_diff = s4_a - s4_b;
  end

  always_comb begin
    s5_dxf = s4_flip_r ? -s4_dx_r : s4_dx_r;
    s5_dyf = s4_flip_r ? -s4_dy_r : s4_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s1_qx_r   <= pivot_x;
      s1_qy_r   <= pivot_y;
      s1_neg_r  <= angle_deg[31];
      s1_mag_r  <= s1_mag_nxt;

      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_qx_r   <= s1_qx_r;
      s2_qy_r   <= s1_qy_r;
      s2_neg_r  <= s1_neg_r;
      s2_h_r    <= s1_mag_r[31:16];
      s2_low_r  <= s1_mag_r[15:0];
      s2_prod_r <= s1_mag_r[31:16] * rpp_pkg::RECIP_360;

      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_qx_r   <= s2_qx_r;
      s3_qy_r   <= s2_qy_r;
      s3_neg_r  <= s2_neg_r;
      s3_m_r    <= {s3_rem[8:0], s2_low_r};

      s4_dx_r   <= s3_dx_r;
      s4_dy_r   <= s3_dy_r;
      s4_qx_r   <= s3_qx_r;
      s4_qy_r   <= s3_qy_r;
      s4_r_r    <= s4_diff[rpp_pkg::RW-1:0];
      s4_flip_r <= s4_flip_nxt;

      s5_qx_r   <= s4_qx_r;
      s5_qy_r   <= s4_qy_r;
      s5_pl_r   <= PW'(s4_r_r) * PW'($signed({1'b0, rpp_pkg::Z_LO}));
      s5_ph_r   <= PW'(s4_r_r) * PW'($signed({1'b0, rpp_pkg::Z_HI}));
      s5_x_r    <= rpp_pkg::CW'(s5_dxf) <<< GUARD;
      s5_y_r    <= rpp_pkg::CW'(s5_dyf) <<< GUARD;

      s6_qx_r   <= s5_qx_r;
      s6_qy_r   <= s5_qy_r;
      s6_vec_r.x <= s5_x_r;
      s6_vec_r.y <= s5_y_r;
      s6_vec_r.z <= (rpp_pkg::CW'(s5_ph_r) <<< rpp_pkg::ZSPLIT) + rpp_pkg::CW'(s5_pl_r);
    end
  end

  assign vec_valid   = valid_r[5];
  assign vec         = s6_vec_r;
  assign vec_pivot_x = s6_qx_r;
  assign vec_pivot_y = s6_qy_r;

endmodule

// ===== design/rpp_cordic_stage.sv =====
// one registered cordic micro-rotation in rotation mode
module rpp_cordic_stage #(
  parameter int COORD_WIDTH = 32,
  parameter int STAGE       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  rpp_pkg::cvec_t                in_vec,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_x,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_y,
  output logic                          out_valid,
  output rpp_pkg::cvec_t                out_vec,
  output logic signed [COORD_WIDTH-1:0] out_pivot_x,
  output logic signed [COORD_WIDTH-1:0] out_pivot_y
);

  logic                          valid_r;
  rpp_pkg::cvec_t                vec_r, vec_nxt;
  logic signed [COORD_WIDTH-1:0] qx_r, qy_r;
  rpp_pkg::cword_t               xs, ys;

  always_comb begin
    xs = in_vec.x >>> STAGE;
    ys = in_vec.y >>> STAGE;
    if (!in_vec.z[rpp_pkg::CW-1]) begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - rpp_pkg::ATAN_TBL[STAGE];
    end else begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + rpp_pkg::ATAN_TBL[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      qx_r  <= in_pivot_x;
      qy_r  <= in_pivot_y;
    end
  end

  assign out_valid   = valid_r;
  assign out_vec     = vec_r;
  assign out_pivot_x = qx_r;
  assign out_pivot_y = qy_r;

endmodule

// ===== design/rpp_gain.sv =====
// gain compensation, guard-bit rounding, pivot add-back and saturation
module rpp_gain #(
  parameter int CORDIC_STAGES = 24,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  rpp_pkg::cword_t               in_x,
  input  rpp_pkg::cword_t               in_y,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_x,
  input  logic signed [COORD_WIDTH-1:0] in_pivot_y,
  output logic                          res_valid,
  output logic signed [COORD_WIDTH-1:0] res_x,
  output logic signed [COORD_WIDTH-1:0] res_y,
  output logic                          res_sat
);

  localparam int W     = COORD_WIDTH;
  localparam int GUARD = rpp_pkg::GUARD_TOTAL - W;
  localparam int MW    = rpp_pkg::CW - GUARD;
  localparam int SW    = W + 5;
  localparam int MAGW  = rpp_pkg::MAGW;
  localparam int AHW   = MAGW - 32;

  localparam logic [63:0] GAIN_S = rpp_pkg::gain_sqrt(CORDIC_STAGES);
  localparam logic [63:0] KINV64 = ((64'd1 << 61) + GAIN_S / 2) / GAIN_S;
  localparam logic [30:0] KINV   = KINV64[30:0];
  localparam logic [rpp_pkg::CW-1:0] HALF = rpp_pkg::CW'(1) << (GUARD - 1);
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (W - 1));

  logic [3:0] valid_r;

  logic                 g1_nx_r, g1_ny_r;
  logic [MAGW-1:0]      g1_ux_r, g1_uy_r;
  rpp_pkg::cword_t      g1_ax, g1_ay;
  logic signed [W-1:0]  g1_qx_r, g1_qy_r;

  logic                 g2_nx_r, g2_ny_r;
  logic [AHW+30:0]      g2_phx_r, g2_phy_r;
  logic [62:0]          g2_plx_r, g2_ply_r;
  logic signed [W-1:0]  g2_qx_r, g2_qy_r;

  logic                 g3_nx_r, g3_ny_r;
  logic [rpp_pkg::CW-1:0] g3_rx_r, g3_ry_r, g3_rx_nxt, g3_ry_nxt;
  logic [63:0]          g3_lox, g3_loy;
  logic signed [W-1:0]  g3_qx_r, g3_qy_r;

  logic                 g4_nx_r, g4_ny_r;
  logic [MW-1:0]        g4_mx_r, g4_my_r;
  logic [rpp_pkg::CW-1:0] g4_sx, g4_sy;
  logic signed [W-1:0]  g4_qx_r, g4_qy_r;

  logic signed [SW-1:0] sum_x, sum_y;
  logic                 hi_x, lo_x, hi_y, lo_y;

  always_comb begin
    g1_ax = in_x[rpp_pkg::CW-1] ? -in_x : in_x;
    g1_ay = in_y[rpp_pkg::CW-1] ? -in_y : in_y;
  end

  // round(|v| * KINV / 2^31) from two partial products, KINV being 1/k in q31
  always_comb begin
    g3_lox    = 64'(g2_plx_r) + (64'd1 << 30);
    g3_loy    = 64'(g2_ply_r) + (64'd1 << 30);
    g3_rx_nxt = (rpp_pkg::CW'(g2_phx_r) << 1) + rpp_pkg::CW'(g3_lox[63:31]);
    g3_ry_nxt = (rpp_pkg::CW'(g2_phy_r) << 1) + rpp_pkg::CW'(g3_loy[63:31]);
  end

  always_comb begin
    g4_sx = g3_rx_r + HALF;
    g4_sy = g3_ry_r + HALF;
  end

  // pivot add-back with the sign of the rotated offset, then clamp
  always_comb begin
    sum_x = g4_nx_r ? SW'(g4_qx_r) - $signed({1'b0, g4_mx_r}) :
                      SW'(g4_qx_r) + $signed({1'b0, g4_mx_r});
    sum_y = g4_ny_r ? SW'(g4_qy_r) - $signed({1'b0, g4_my_r}) :
                      SW'(g4_qy_r) + $signed({1'b0, g4_my_r});
    hi_x  = sum_x > MAXV;
    lo_x  = sum_x < MINV;
    hi_y  = sum_y > MAXV;
    lo_y  = sum_y < MINV;
    res_x = hi_x ? MAXV[W-1:0] : (lo_x ? MINV[W-1:0] : sum_x[W-1:0]);
    res_y = hi_y ? MAXV[W-1:0] : (lo_y ? MINV[W-1:0] : sum_y[W-1:0]);
    res_sat = hi_x || lo_x || hi_y || lo_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_nx_r  <= in_x[rpp_pkg::CW-1];
      g1_ny_r  <= in_y[rpp_pkg::CW-1];
      g1_ux_r  <= g1_ax[MAGW-1:0];
      g1_uy_r  <= g1_ay[MAGW-1:0];
      g1_qx_r  <= in_pivot_x;
      g1_qy_r  <= in_pivot_y;

      g2_nx_r  <= g1_nx_r;
      g2_ny_r  <= g1_ny_r;
      g2_phx_r <= g1_ux_r[MAGW-1:32] * KINV;
      g2_phy_r <= g1_uy_r[MAGW-1:32] * KINV;
      g2_plx_r <= g1_ux_r[31:0] * KINV;
      g2_ply_r <= g1_uy_r[31:0] * KINV;
      g2_qx_r  <= g1_qx_r;
      g2_qy_r  <= g1_qy_r;

      g3_nx_r  <= g2_nx_r;
      g3_ny_r  <= g2_ny_r;
      g3_rx_r  <= g3_rx_nxt;
      g3_ry_r  <= g3_ry_nxt;
      g3_qx_r  <= g2_qx_r;
      g3_qy_r  <= g2_qy_r;

      g4_nx_r  <= g3_nx_r;
      g4_ny_r  <= g3_ny_r;
      g4_mx_r  <= g4_sx[rpp_pkg::CW-1:GUARD];
      g4_my_r  <= g4_sy[rpp_pkg::CW-1:GUARD];
      g4_qx_r  <= g3_qx_r;
      g4_qy_r  <= g3_qy_r;
    end
  end

  assign res_valid = valid_r[3];

endmodule

// ===== design/rotate_point_about_pivot_core.sv =====
// throughput: one transfer per cycle while in_ready is high; front end 6 stages,
// one stage per cordic step, gain path 4 stages, then a result register backed
// by one skid entry
// in_ready drops only while the skid entry is full, which stalls the whole pipeline
// reset (synchronous, rst_n low) clears the valid bits and output queue only
`include "assert_macros.svh"

module rotate_point_about_pivot_core #(
  parameter int CORDIC_STAGES = 24,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_WIDTH-1:0]    in_point_x,
  input  logic signed [COORD_WIDTH-1:0]    in_point_y,
  input  logic signed [COORD_WIDTH-1:0]    in_pivot_x,
  input  logic signed [COORD_WIDTH-1:0]    in_pivot_y,
  input  logic signed [rpp_pkg::ANG_W-1:0] in_angle_deg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COORD_WIDTH-1:0]    out_rotated_x,
  output logic signed [COORD_WIDTH-1:0]    out_rotated_y,
  output logic                             out_saturated
);

  localparam int W = COORD_WIDTH;
  localparam int N = CORDIC_STAGES;

  // coordinate range limits
  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

  // global pipeline advance: every stage moves together unless the skid entry is full
  logic en;

  // cordic chain: index 0 is the front end output, index N the last rotation
  rpp_pkg::cvec_t      stg_vec [0:N];
  logic [N:0]          stg_valid;
  logic signed [W-1:0] stg_qx [0:N];
  logic signed [W-1:0] stg_qy [0:N];

  // gain path result, combinational off its last register
  logic                res_valid;
  logic signed [W-1:0] res_x, res_y;
  logic                res_sat;

  // output register plus one skid entry
  logic                out_valid_r, skid_valid_r;
  logic signed [W-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                out_sat_r, skid_sat_r;
  logic                push, pop;

  // held coordinate sits on a range limit
  logic                x_at_limit, y_at_limit;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  rpp_front #(
    .COORD_WIDTH (W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .pivot_x     (in_pivot_x),
    .pivot_y     (in_pivot_y),
    .angle_deg   (in_angle_deg),
    .vec_valid   (stg_valid[0]),
    .vec         (stg_vec[0]),
    .vec_pivot_x (stg_qx[0]),
    .vec_pivot_y (stg_qy[0])
  );

  // one micro-rotation per stage, shift and arctangent fixed by position
  for (genvar g = 0; g < N; g++) begin : g_cordic
    rpp_cordic_stage #(
      .COORD_WIDTH (W),
      .STAGE       (g)
    ) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (stg_valid[g]),
      .in_vec      (stg_vec[g]),
      .in_pivot_x  (stg_qx[g]),
      .in_pivot_y  (stg_qy[g]),
      .out_valid   (stg_valid[g+1]),
      .out_vec     (stg_vec[g+1]),
      .out_pivot_x (stg_qx[g+1]),
      .out_pivot_y (stg_qy[g+1])
    );
  end

  rpp_gain #(
    .CORDIC_STAGES (N),
    .COORD_WIDTH   (W)
  ) u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (stg_valid[N]),
    .in_x       (stg_vec[N].x),
    .in_y       (stg_vec[N].y),
    .in_pivot_x (stg_qx[N]),
    .in_pivot_y (stg_qy[N]),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_sat    (res_sat)
  );

  // a finished item leaves the pipeline only on an advancing cycle
  assign push = en && res_valid;
  assign pop  = out_valid_r && out_ready;

  // output queue control: skid drains first, else the new result lands in the
  // output register; if the output register is held, the new result parks in skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_x_r   <= skid_x_r;
        out_y_r   <= skid_y_r;
        out_sat_r <= skid_sat_r;
      end else if (push) begin
        out_x_r   <= res_x;
        out_y_r   <= res_y;
        out_sat_r <= res_sat;
      end
    end else if (push) begin
      skid_x_r   <= res_x;
      skid_y_r   <= res_y;
      skid_sat_r <= res_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = out_x_r;
  assign out_rotated_y = out_y_r;
  assign out_saturated = out_sat_r;

  assign x_at_limit = (out_x_r == COORD_MAX) || (out_x_r == COORD_MIN);
  assign y_at_limit = (out_y_r == COORD_MAX) || (out_y_r == COORD_MIN);

  // skid entry only ever fills behind a held output register
  `RPP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // after a result leaves the pipeline, the output register is valid on the next cycle
  `RPP_ASSERT_NXT(a_push_lands, clk, rst_n, push, out_valid_r)
  // a result pushed while the output is held must park in the skid entry
  `RPP_ASSERT_NXT(a_push_parks, clk, rst_n, push && out_valid_r && !out_ready, skid_valid_r)
  // saturation flag implies a coordinate sits at a range limit
  `RPP_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid_r && out_sat_r, x_at_limit || y_at_limit)

endmodule

// ===== tb/tb.sv =====
// testbench for rotate_point_about_pivot_core: directed and random points vs a cordic predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // block configuration under test (defaults of the core)
  localparam int STAGES  = 24;
  localparam int CWIDTH  = 32;
  localparam int GUARD   = 58 - CWIDTH;
  localparam int LATENCY = STAGES + 11;

  // angle constants in q16.16 degrees
  localparam longint ONE_DEG      = 65536;
  localparam longint QUARTER_TURN = 90 * ONE_DEG;
  localparam longint HALF_TURN    = 180 * ONE_DEG;
  localparam longint FULL_TURN    = 360 * ONE_DEG;
  // q16.16 degrees times 5^16 gives the cordic angle unit of 1e-16 degree
  localparam longint DEG_TO_ZUNITS = 64'sd152587890625;

  typedef logic signed [CWIDTH-1:0]         coord_t;
  typedef logic signed [rpp_pkg::ANG_W-1:0] angle_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   sat;
  } rot_result_t;

  localparam coord_t C_MAX   = {1'b0, {(CWIDTH-1){1'b1}}};
  localparam coord_t C_MIN   = {1'b1, {(CWIDTH-1){1'b0}}};
  localparam angle_t ANG_MAX = {1'b0, {(rpp_pkg::ANG_W-1){1'b1}}};
  localparam angle_t ANG_MIN = {1'b1, {(rpp_pkg::ANG_W-1){1'b0}}};

  // atan(2^-i) in units of 1e-16 degree
  longint atan_e16 [0:31] = '{
    64'sd450000000000000000, 64'sd265650511770779900, 64'sd140362434679264790,
    64'sd71250163489017980,  64'sd35763343749973510,  64'sd17899106082460690,
    64'sd8951737102110744,   64'sd4476141708605531,   64'sd2238105003685381,
    64'sd1119056770662069,   64'sd559528918938037,    64'sd279764526170037,
    64'sd139882271422650,    64'sd69941136753529,     64'sd34970568507040,
    64'sd17485284269804,     64'sd8742642136938,      64'sd4371321068723,
    64'sd2185660534393,      64'sd1092830267201,      64'sd546415133601,
    64'sd273207566800,       64'sd136603783400,       64'sd68301891700,
    64'sd34150945850,        64'sd17075472925,        64'sd8537736463,
    64'sd4268868231,         64'sd2134434116,         64'sd1067217058,
    64'sd533608529,          64'sd266804264
  };

  logic clk;
  logic rst_n = 1'b0;

  logic   in_valid   = 1'b0;
  logic   in_ready;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_pivot_x = '0;
  coord_t in_pivot_y = '0;
  angle_t in_angle_deg = '0;

  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_rotated_x;
  coord_t out_rotated_y;
  logic   out_saturated;

  // 1/k in q31, worked out once at time zero
  logic [63:0] inv_gain;

  // predicted rotations waiting for their output transfer, oldest first
  rot_result_t pending_rotations [$];
  int          mismatch_count = 0;

  // traffic shaping knobs, flipped by the test tasks
  bit src_gaps_on      = 1'b0;
  bit sink_stalls_on   = 1'b0;
  int sink_hold_cycles = 0;

  rotate_point_about_pivot_core #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH  (CWIDTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_pivot_x   (in_pivot_x),
    .in_pivot_y   (in_pivot_y),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #1_000_000;
    $display("rotate_point_about_pivot_core test failed");
    $finish;
  end

  // gain compensation: product of (1 + 4^-i) in q60 with truncated partial products,
  // floor square root by bisection, then 2^61 / sqrt rounded to nearest
  initial begin : gain_setup
    logic [63:0]  prod_q60;
    logic [127:0] lo_r;
    logic [127:0] hi_r;
    logic [127:0] mid;
    prod_q60 = 64'd1 << 60;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      prod_q60 = prod_q60 + (prod_q60 >> (2 * i));
    end
    lo_r = '0;
    hi_r = 128'd1 << 32;
    while (lo_r < hi_r) begin
      mid = (lo_r + hi_r + 128'd1) >> 1;
      if (mid * mid <= 128'(prod_q60)) begin
        lo_r = mid;
      end else begin
        hi_r = mid - 128'd1;
      end
    end
    if (lo_r == '0) begin
      lo_r = 128'd1;
    end
    inv_gain = 64'(((128'd1 << 61) + (lo_r >> 1)) / lo_r);
  end

  // round(v * invK / 2^31), half away from zero
  function automatic longint apply_gain(longint v);
    logic [127:0] mag;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    mag = (mag * inv_gain + (128'd1 << 30)) >> 31;
    return (v < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // drop the guard bits, half away from zero
  function automatic longint unscale(longint v);
    longint half;
    half = longint'(1) << (GUARD - 1);
    return (v >= 0) ? ((v + half) >>> GUARD) : -((-v + half) >>> GUARD);
  endfunction

  function automatic coord_t saturate(longint v, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CWIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (CWIDTH - 1));
    if (v > hi) begin
      sat = 1'b1;
      return coord_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  // expected rotated point for one input transfer
  function automatic rot_result_t predict_rotation(coord_t px, coord_t py, coord_t qx,
                                                   coord_t qy, angle_t ang);
    longint      dx;
    longint      dy;
    longint      turn;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      ny;
    bit          sat;
    rot_result_t res;
    dx = longint'(px) - longint'(qx);
    dy = longint'(py) - longint'(qy);
    // truncating remainder keeps the sign of the angle
    turn = longint'(ang) % FULL_TURN;
    if (turn > HALF_TURN) begin
      turn = turn - FULL_TURN;
    end
    if (turn < -HALF_TURN) begin
      turn = turn + FULL_TURN;
    end
    // fold into [-90, 90] and turn the offset by half a turn instead
    if (turn > QUARTER_TURN) begin
      turn = turn - HALF_TURN;
      dx   = -dx;
      dy   = -dy;
    end else if (turn < -QUARTER_TURN) begin
      turn = turn + HALF_TURN;
      dx   = -dx;
      dy   = -dy;
    end
    z = turn * DEG_TO_ZUNITS;
    x = dx * (longint'(1) << GUARD);
    y = dy * (longint'(1) << GUARD);
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_e16[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_e16[i];
      end
      x = nx;
      y = ny;
    end
    sat     = 1'b0;
    res.x   = saturate(longint'(qx) + unscale(apply_gain(x)), sat);
    res.y   = saturate(longint'(qy) + unscale(apply_gain(y)), sat);
    res.sat = sat;
    return res;
  endfunction

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    rot_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rotations.size() == 0) begin
        mismatch_count++;
        $display("%0t: output transfer, expected none, got x=%0d y=%0d sat=%0b",
                 $time, out_rotated_x, out_rotated_y, out_saturated);
      end else begin
        want = pending_rotations.pop_front();
        if (out_rotated_x !== want.x) begin
          mismatch_count++;
          $display("%0t: rotated_x mismatch, expected %0d, got %0d",
                   $time, want.x, out_rotated_x);
        end
        if (out_rotated_y !== want.y) begin
          mismatch_count++;
          $display("%0t: rotated_y mismatch, expected %0d, got %0d",
                   $time, want.y, out_rotated_y);
        end
        if (out_saturated !== want.sat) begin
          mismatch_count++;
          $display("%0t: saturated mismatch, expected %0b, got %0b",
                   $time, want.sat, out_saturated);
        end
      end
    end
  end

  // result receiver: random stall before each transfer, or a long hold-off on request
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        n = sink_stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      // a hold-off request cuts the wait short so it starts right away
      do @(posedge clk); while (!(out_valid && out_ready) && sink_hold_cycles == 0);
    end
  end

  // offers one point and returns at the edge where the transfer happens;
  // valid stays high afterwards so back-to-back items need no extra edge
  task automatic send_point(input coord_t px, input coord_t py, input coord_t qx,
                            input coord_t qy, input angle_t ang);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_point_x   <= px;
    in_point_y   <= py;
    in_pivot_x   <= qx;
    in_pivot_y   <= qy;
    in_angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    pending_rotations.push_back(predict_rotation(px, py, qx, qy, ang));
  endtask

  // random point: coordinate and angle classes drawn independently
  task automatic send_random_point();
    coord_t px;
    coord_t py;
    coord_t qx;
    coord_t qy;
    angle_t ang;
    int     coord_kind;
    int     angle_kind;
    coord_kind = $urandom_range(0, 99);
    angle_kind = $urandom_range(0, 99);
    px  = $urandom;
    py  = $urandom;
    qx  = $urandom;
    qy  = $urandom;
    ang = $urandom;
    if (coord_kind >= 35 && coord_kind < 70) begin
      // moderate coordinates, within +-32 units
      px = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      py = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      qx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      qy = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    end else if (coord_kind >= 70 && coord_kind < 88) begin
      // pivot hugging the range limits, offset large enough to clamp often
      qx = $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 1 << 20)
                                : C_MIN + $urandom_range(0, 1 << 20);
      qy = $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 1 << 20)
                                : C_MIN + $urandom_range(0, 1 << 20);
      px = qx + (int'($urandom_range(0, 1 << 25)) - (1 << 24));
      py = qy + (int'($urandom_range(0, 1 << 25)) - (1 << 24));
    end else if (coord_kind >= 88) begin
      // tiny offsets around a random pivot
      px = qx + (int'($urandom_range(0, 16)) - 8);
      py = qy + (int'($urandom_range(0, 16)) - 8);
    end
    if (angle_kind >= 40 && angle_kind < 65) begin
      // multiples of a quarter turn, a few lsb either side
      ang = (int'($urandom_range(0, 720)) - 360) * 90 * 65536
            + (int'($urandom_range(0, 4)) - 2);
    end else if (angle_kind >= 65) begin
      // within two turns either way
      ang = int'($urandom_range(0, 2 * 720 * 65536)) - 720 * 65536;
    end
    send_point(px, py, qx, qy, ang);
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rotations.size() != 0);
  endtask

  // field extremes, every folding branch of the angle, clamping both ways
  task automatic test_directed_cases();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_point(0, 0, 0, 0, 0);                          // all zero
    send_point(65536, 0, 0, 0, 90 * 65536);             // quarter turn ccw
    send_point(65536, 0, 0, 0, -90 * 65536);            // quarter turn cw
    send_point(65536, 131072, 0, 0, 180 * 65536);       // exactly half turn
    send_point(65536, 131072, 0, 0, -180 * 65536);
    send_point(65536, 131072, 0, 0, 180 * 65536 + 1);   // just past half turn
    send_point(65536, 131072, 0, 0, -180 * 65536 - 1);
    send_point(65536, -65536, 0, 0, 90 * 65536 + 1);    // just past quarter turn
    send_point(65536, -65536, 0, 0, -90 * 65536 - 1);
    send_point(300000, 200000, 10000, -5000, 270 * 65536);
    send_point(300000, 200000, 10000, -5000, 360 * 65536); // full turn
    send_point(300000, 200000, 10000, -5000, -720 * 65536);
    send_point(400000, -700000, 0, 0, 45 * 65536);
    send_point(123456, -654321, 1000, 2000, ANG_MAX);   // angle extremes
    send_point(123456, -654321, 1000, 2000, ANG_MIN);
    send_point(777777, -333333, 777777, -333333, 37 * 65536); // zero offset
    send_point(C_MAX, C_MAX, C_MIN, C_MIN, 0);          // largest offset
    send_point(C_MAX, C_MAX, C_MIN, C_MIN, 180 * 65536);
    send_point(C_MIN, C_MIN, C_MAX, C_MAX, 180 * 65536);
    send_point(C_MAX, C_MIN, 0, 0, 45 * 65536);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX, 90 * 65536);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN, -90 * 65536);
    send_point(C_MAX - 100, 0, C_MAX - 1000000, 0, 60 * 65536);
    send_point(1, 0, 0, 0, 90 * 65536);                 // one-lsb offset
  endtask

  // long random stream in stretches with and without idling on either side
  task automatic test_random_stream();
    for (int seg = 0; seg < 15; seg++) begin
      src_gaps_on    = ($urandom_range(0, 2) != 0);
      sink_stalls_on = ($urandom_range(0, 2) != 0);
      repeat (100) send_random_point();
    end
  endtask

  // receiver holds off while the sender keeps going, so the pipeline fills
  // and in_ready has to drop
  task automatic test_output_backpressure();
    src_gaps_on      = 1'b0;
    sink_stalls_on   = 1'b0;
    sink_hold_cycles = 300;
    repeat (150) send_random_point();
  endtask

  // bursts separated by a full drain of the pipeline
  task automatic test_drain_pauses();
    repeat (4) begin
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
      repeat (25) send_random_point();
      wait_for_drain();
    end
  endtask

  initial begin : main_flow
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_stream();
    test_output_backpressure();
    test_drain_pauses();

    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rotate_point_about_pivot_core test passed");
    end else begin
      $display("rotate_point_about_pivot_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rpp_pkg.sv
design/rpp_front.sv
design/rpp_cordic_stage.sv
design/rpp_gain.sv
design/rotate_point_about_pivot_core.sv
tb/tb.sv
